// ===== hdl/lsv_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the normalized legendre value block
// used by lsv_sqrt and legendre_single_value; depends on nothing
package lsv_pkg;

    typedef logic [63:0] t_word;

    localparam t_word C0_Q40 = 64'd310166503690;
    localparam t_word VSAT   = 64'h0000_0FFF_FFFF_FFFF;
    localparam t_word MSAT   = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam t_word ONE_60 = 64'h1000_0000_0000_0000;

    function automatic t_word mag(input t_word v);
        return v[63] ? t_word'(-v) : v;
    endfunction

    function automatic t_word vclamp(input t_word v);
        t_word r;
        r = v;
        if ($signed(v) > $signed(VSAT)) begin
            r = VSAT;
        end else if ($signed(v) < -$signed(VSAT)) begin
            r = t_word'(-VSAT);
        end
        return r;
    endfunction

endpackage

// ===== hdl/legendre_single_value.sv =====
`timescale 1ns / 1ps
// fully normalized associated legendre function X_l^m(x), one value per request
// depends on lsv_pkg and lsv_sqrt
//
// channel   direction  handshake           payload
// request   in         i_valid / o_stall   i_degree, i_order, i_arg_cos
// result    out        o_valid / i_stall   o_value, o_bad_args
//
// one request at a time; square roots are computed in lsv_sqrt and products on the
// shared 32x32 multiplier (four partial products); a rejected request skips the
// computation and goes straight to the output state
// synchronous active-low reset returns to idle with no result pending
// a finished result waits in the output register while the next request is taken
module legendre_single_value #(
    parameter int MAX_DEGREE = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_degree,
    input  logic [7:0]  i_order,
    input  logic [31:0] i_arg_cos,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic        o_bad_args
);

    localparam logic [9:0] LP_MAXD = 10'(MAX_DEGREE);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL  = 5'd1;
    localparam logic [4:0] S_MFIN = 5'd2;
    localparam logic [4:0] S_SQ   = 5'd3;
    localparam logic [4:0] S_XX   = 5'd4;
    localparam logic [4:0] S_S    = 5'd5;
    localparam logic [4:0] S_FI   = 5'd6;
    localparam logic [4:0] S_PMS  = 5'd7;
    localparam logic [4:0] S_PMF  = 5'd8;
    localparam logic [4:0] S_PMF2 = 5'd9;
    localparam logic [4:0] S_PMN  = 5'd10;
    localparam logic [4:0] S_CHKL = 5'd11;
    localparam logic [4:0] S_C3   = 5'd12;
    localparam logic [4:0] S_T1   = 5'd13;
    localparam logic [4:0] S_PM1  = 5'd14;
    localparam logic [4:0] S_CA   = 5'd15;
    localparam logic [4:0] S_CB   = 5'd16;
    localparam logic [4:0] S_CC   = 5'd17;
    localparam logic [4:0] S_CD   = 5'd18;
    localparam logic [4:0] S_CE   = 5'd19;
    localparam logic [4:0] S_CF   = 5'd20;
    localparam logic [4:0] S_CG   = 5'd21;
    localparam logic [4:0] S_CH   = 5'd22;
    localparam logic [4:0] S_CI   = 5'd23;
    localparam logic [4:0] S_CJ   = 5'd24;
    localparam logic [4:0] S_CK   = 5'd25;
    localparam logic [4:0] S_OUT  = 5'd26;

    logic [4:0]     r_state;
    logic [4:0]     r_ret;
    logic [7:0]     r_l;
    logic [7:0]     r_m;
    logic [7:0]     r_i;
    logic [7:0]     r_ll;
    logic           r_bad;
    lsv_pkg::t_word r_xq;
    lsv_pkg::t_word r_pm;
    lsv_pkg::t_word r_pm1;
    lsv_pkg::t_word r_s;
    lsv_pkg::t_word r_f;
    lsv_pkg::t_word r_f1;
    lsv_pkg::t_word r_f2;
    lsv_pkg::t_word r_t;
    lsv_pkg::t_word r_na;
    lsv_pkg::t_word r_da;
    lsv_pkg::t_word r_nb;
    lsv_pkg::t_word r_res;
    lsv_pkg::t_word r_ma;
    lsv_pkg::t_word r_mb;
    logic           r_mneg;
    logic [2:0]     r_mcnt;
    lsv_pkg::t_word r_pp;
    logic [127:0]   r_prod;
    lsv_pkg::t_word r_mq;
    lsv_pkg::t_word r_mraw;
    logic           r_sq_go;
    lsv_pkg::t_word r_sq_num;
    lsv_pkg::t_word r_sq_den;
    logic           r_ovalid;
    logic [31:0]    r_oval;
    logic           r_obad;

    logic           w_acc;
    logic           w_inbad;
    logic           w_sq_done;
    lsv_pkg::t_word w_root;
    logic [31:0]    w_pa;
    logic [31:0]    w_pb;
    lsv_pkg::t_word w_pp;
    logic [2:0]     w_pcnt;
    logic [127:0]   w_ppx;
    logic [127:0]   w_rnd;
    lsv_pkg::t_word w_rq;
    logic [8:0]     w_tw;
    logic [8:0]     w_lp;
    logic [7:0]     w_lm;
    lsv_pkg::t_word w_rmag;
    lsv_pkg::t_word w_r;
    logic [31:0]    w_oval;
    lsv_pkg::t_word w_diff;
    lsv_pkg::t_word w_xmag;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_inbad = (i_order > i_degree) || ({2'b00, i_degree} > LP_MAXD)
                  || ($signed(i_arg_cos) > 32'sd1073741824)
                  || ($signed(i_arg_cos) < -32'sd1073741824);
    assign w_xmag  = lsv_pkg::mag({{32{i_arg_cos[31]}}, i_arg_cos});

    assign w_pa   = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_pb   = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp   = w_pa * w_pb;
    assign w_pcnt = r_mcnt - 3'd1;
    assign w_ppx  = (w_pcnt == 3'd0) ? {64'd0, r_pp} :
                    (w_pcnt == 3'd3) ? {r_pp, 64'd0} : {32'd0, r_pp, 32'd0};
    assign w_rnd  = r_prod + (128'd1 << 39);
    assign w_rq   = (|w_rnd[127:100]) ? lsv_pkg::MSAT : {4'd0, w_rnd[99:40]};

    assign w_tw = {r_ll, 1'b0};
    assign w_lp = {1'b0, r_ll} + {1'b0, r_m};
    assign w_lm = r_ll - r_m;

    assign w_diff = r_t - r_mq;

    assign w_rmag = lsv_pkg::mag(r_res) + 64'd4096;
    assign w_r    = w_rmag >> 13;
    always_comb begin
        if (r_res[63]) begin
            w_oval = (w_r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-w_r);
        end else begin
            w_oval = (w_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_r[31:0];
        end
    end

    lsv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_num   (r_sq_num),
        .i_den   (r_sq_den),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_mcnt   <= '0;
            r_sq_go  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_sq_go <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_l  <= i_degree;
                        r_m  <= i_order;
                        r_xq <= {{22{i_arg_cos[31]}}, i_arg_cos, 10'd0};
                        r_pm <= lsv_pkg::C0_Q40;
                        r_i  <= 8'd1;
                        if (w_inbad) begin
                            r_bad   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_bad <= 1'b0;
                            if (i_order != 8'd0) begin
                                r_ma    <= w_xmag;
                                r_mb    <= w_xmag;
                                r_mneg  <= 1'b0;
                                r_mcnt  <= '0;
                                r_prod  <= '0;
                                r_ret   <= S_XX;
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_CHKL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    if (r_mcnt != 3'd4) begin
                        r_pp <= w_pp;
                    end
                    if (r_mcnt != 3'd0) begin
                        r_prod <= r_prod + w_ppx;
                    end
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_mcnt == 3'd4) begin
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    r_mq    <= r_mneg ? lsv_pkg::t_word'(-w_rq) : w_rq;
                    r_mraw  <= r_prod[63:0];
                    r_state <= r_ret;
                end
                S_SQ: begin
                    if (w_sq_done) begin
                        r_state <= r_ret;
                    end
                end
                S_XX: begin
                    r_sq_num <= lsv_pkg::ONE_60 - r_mraw;
                    r_sq_den <= lsv_pkg::ONE_60;
                    r_sq_go  <= 1'b1;
                    r_ret    <= S_S;
                    r_state  <= S_SQ;
                end
                S_S: begin
                    r_s     <= w_root;
                    r_state <= S_FI;
                end
                S_FI: begin
                    r_sq_num <= 64'({r_i, 1'b1});
                    r_sq_den <= 64'({r_i, 1'b0});
                    r_sq_go  <= 1'b1;
                    r_ret    <= S_PMS;
                    r_state  <= S_SQ;
                end
                S_PMS: begin
                    r_f     <= w_root;
                    r_ma    <= lsv_pkg::mag(r_pm);
                    r_mb    <= r_s;
                    r_mneg  <= r_pm[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_PMF;
                    r_state <= S_MUL;
                end
                S_PMF: begin
                    r_pm    <= lsv_pkg::vclamp(r_mq);
                    r_state <= S_PMF2;
                end
                S_PMF2: begin
                    r_ma    <= lsv_pkg::mag(r_pm);
                    r_mb    <= r_f;
                    r_mneg  <= !r_pm[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_PMN;
                    r_state <= S_MUL;
                end
                S_PMN: begin
                    r_pm <= lsv_pkg::vclamp(r_mq);
                    r_i  <= r_i + 8'd1;
                    r_state <= (r_i == r_m) ? S_CHKL : S_FI;
                end
                S_CHKL: begin
                    if (r_l == r_m) begin
                        r_res   <= r_pm;
                        r_state <= S_OUT;
                    end else begin
                        r_sq_num <= 64'({r_m, 1'b1}) + 64'd2;
                        r_sq_den <= 64'd1;
                        r_sq_go  <= 1'b1;
                        r_ret    <= S_C3;
                        r_state  <= S_SQ;
                    end
                end
                S_C3: begin
                    r_f1    <= w_root;
                    r_ma    <= lsv_pkg::mag(r_xq);
                    r_mb    <= lsv_pkg::mag(r_pm);
                    r_mneg  <= r_xq[63] ^ r_pm[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_T1;
                    r_state <= S_MUL;
                end
                S_T1: begin
                    r_ma    <= lsv_pkg::mag(r_mq);
                    r_mb    <= r_f1;
                    r_mneg  <= r_mq[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_PM1;
                    r_state <= S_MUL;
                end
                S_PM1: begin
                    r_pm1 <= lsv_pkg::vclamp(r_mq);
                    r_ll  <= r_m + 8'd2;
                    if (r_l == r_m + 8'd1) begin
                        r_res   <= lsv_pkg::vclamp(r_mq);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CA;
                    end
                end
                S_CA: begin
                    r_ma    <= 64'(w_tw + 9'd1);
                    r_mb    <= 64'(w_tw - 9'd1);
                    r_mneg  <= 1'b0;
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CB;
                    r_state <= S_MUL;
                end
                S_CB: begin
                    r_na    <= r_mraw;
                    r_ma    <= 64'(w_lp);
                    r_mb    <= 64'(w_lm);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CC;
                    r_state <= S_MUL;
                end
                S_CC: begin
                    r_da    <= r_mraw;
                    r_ma    <= 64'(w_lm - 8'd1);
                    r_mb    <= 64'(w_lp - 9'd1);
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CD;
                    r_state <= S_MUL;
                end
                S_CD: begin
                    r_ma    <= 64'(w_tw + 9'd1);
                    r_mb    <= r_mraw;
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CE;
                    r_state <= S_MUL;
                end
                S_CE: begin
                    r_nb    <= r_mraw;
                    r_ma    <= 64'(w_tw - 9'd3);
                    r_mb    <= r_da;
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CF;
                    r_state <= S_MUL;
                end
                S_CF: begin
                    r_sq_num <= r_na;
                    r_sq_den <= r_da;
                    r_sq_go  <= 1'b1;
                    r_ret    <= S_CG;
                    r_state  <= S_SQ;
                end
                S_CG: begin
                    r_f1     <= w_root;
                    r_sq_num <= r_nb;
                    r_sq_den <= r_mraw;
                    r_sq_go  <= 1'b1;
                    r_ret    <= S_CH;
                    r_state  <= S_SQ;
                end
                S_CH: begin
                    r_f2    <= w_root;
                    r_ma    <= lsv_pkg::mag(r_xq);
                    r_mb    <= lsv_pkg::mag(r_pm1);
                    r_mneg  <= r_xq[63] ^ r_pm1[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CI;
                    r_state <= S_MUL;
                end
                S_CI: begin
                    r_ma    <= lsv_pkg::mag(r_mq);
                    r_mb    <= r_f1;
                    r_mneg  <= r_mq[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CJ;
                    r_state <= S_MUL;
                end
                S_CJ: begin
                    r_t     <= r_mq;
                    r_ma    <= r_f2;
                    r_mb    <= lsv_pkg::mag(r_pm);
                    r_mneg  <= r_pm[63];
                    r_mcnt  <= '0;
                    r_prod  <= '0;
                    r_ret   <= S_CK;
                    r_state <= S_MUL;
                end
                S_CK: begin
                    r_pm  <= r_pm1;
                    r_pm1 <= lsv_pkg::vclamp(w_diff);
                    r_ll  <= r_ll + 8'd1;
                    if (r_ll == r_l) begin
                        r_res   <= lsv_pkg::vclamp(w_diff);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CA;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_bad ? 32'd0 : w_oval;
                        r_obad   <= r_bad;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_value    = r_oval;
    assign o_bad_args = r_obad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_args) |-> (o_value == 32'd0))
        else $error("rejected request carries a nonzero value");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken but block not busy");

    a_sq_go_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_go |-> (r_state == S_SQ))
        else $error("square root started outside its wait state");

    a_mul_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mcnt <= 3'd4))
        else $error("multiplier step count out of range");

endmodule

// ===== hdl/lsv_sqrt.sv =====
`timescale 1ns / 1ps
// floor(sqrt(num/den) * 2^40): bit-serial long division feeding a bitwise square root
// depends on lsv_pkg
module lsv_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lsv_pkg::t_word i_num,
    input  lsv_pkg::t_word i_den,
    output logic          o_done,
    output lsv_pkg::t_word o_root
);

    localparam logic [2:0] SQ_IDLE  = 3'd0;
    localparam logic [2:0] SQ_DIV   = 3'd1;
    localparam logic [2:0] SQ_CLAMP = 3'd2;
    localparam logic [2:0] SQ_IPAIR = 3'd3;
    localparam logic [2:0] SQ_FB0   = 3'd4;
    localparam logic [2:0] SQ_FB1   = 3'd5;
    localparam logic [2:0] SQ_ROOT  = 3'd6;
    localparam logic [2:0] SQ_DONE  = 3'd7;

    logic [2:0]     r_state;
    logic [5:0]     r_cnt;
    lsv_pkg::t_word r_num;
    lsv_pkg::t_word r_den;
    lsv_pkg::t_word r_rem;
    lsv_pkg::t_word r_quo;
    logic [33:0]    r_ip;
    lsv_pkg::t_word r_acc;
    lsv_pkg::t_word r_root;
    logic [1:0]     r_pair;
    logic           r_done;

    logic           w_feed;
    logic [64:0]    w_remsh;
    logic           w_dge;
    logic [64:0]    w_remnx;
    logic [1:0]     w_pairin;
    lsv_pkg::t_word w_accsh;
    lsv_pkg::t_word w_trial;
    logic           w_rge;

    assign w_feed   = (r_state == SQ_DIV) ? r_num[63] : 1'b0;
    assign w_remsh  = {r_rem, w_feed};
    assign w_dge    = w_remsh >= {1'b0, r_den};
    assign w_remnx  = w_dge ? (w_remsh - {1'b0, r_den}) : w_remsh;
    assign w_pairin = (r_state == SQ_IPAIR) ? r_ip[33:32] : r_pair;
    assign w_accsh  = {r_acc[61:0], w_pairin};
    assign w_trial  = {r_root[61:0], 2'b01};
    assign w_rge    = w_accsh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SQ_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= SQ_DIV;
                    end
                end
                SQ_DIV: begin
                    r_rem <= w_remnx[63:0];
                    r_quo <= {r_quo[62:0], w_dge};
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= SQ_CLAMP;
                    end
                end
                SQ_CLAMP: begin
                    r_ip    <= (|r_quo[63:34]) ? '1 : r_quo[33:0];
                    r_acc   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= SQ_IPAIR;
                end
                SQ_IPAIR: begin
                    r_acc  <= w_rge ? (w_accsh - w_trial) : w_accsh;
                    r_root <= {r_root[62:0], w_rge};
                    r_ip   <= {r_ip[31:0], 2'b00};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd16) begin
                        r_state <= SQ_FB0;
                    end
                end
                SQ_FB0: begin
                    r_rem     <= w_remnx[63:0];
                    r_pair[1] <= w_dge;
                    r_state   <= SQ_FB1;
                end
                SQ_FB1: begin
                    r_rem     <= w_remnx[63:0];
                    r_pair[0] <= w_dge;
                    r_state   <= SQ_ROOT;
                end
                SQ_ROOT: begin
                    r_acc  <= w_rge ? (w_accsh - w_trial) : w_accsh;
                    r_root <= {r_root[62:0], w_rge};
                    r_cnt  <= r_cnt + 6'd1;
                    r_state <= (r_cnt == 6'd56) ? SQ_DONE : SQ_FB0;
                end
                SQ_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= SQ_IDLE;
                end
                default: begin
                    r_state <= SQ_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
